// ===== src/hblm_pkg.sv =====
package hblm_pkg;

    // Field widths fixed by the stream format
    localparam int CMD_W     = 2;
    localparam int SLOT_W    = 4;
    localparam int NOW_W     = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 8;
    localparam int S_TDATA_W = 40;  // client_slot + now_ms, padded to whole bytes
    localparam int M_TDATA_W = 8;   // target_slot, padded to a byte

    // Command codes (s_axis_tuser)
    localparam logic [CMD_W-1:0] CMD_HELLO     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GOODBYE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_HEARTBEAT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_POLL      = 2'd3;

    // Message kinds (m_axis_tuser)
    localparam logic KIND_GOODBYE   = 1'b0;
    localparam logic KIND_HEARTBEAT = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEND_PERIOD = 8'd1;

    localparam logic [CFG_W-1:0] TIMEOUT_RST     = 32'd1000;
    localparam logic [CFG_W-1:0] SEND_PERIOD_RST = 32'd100;

    // Request from the sequencer to the output buffer
    typedef struct packed {
        logic              push;   // new message to queue
        logic              flush;  // end of poll: release the held message as last
        logic              kind;
        logic [SLOT_W-1:0] slot;
    } t_emit_req;

endpackage

// ===== src/hblm_ram.sv =====
module hblm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/hblm_elapsed.sv =====
module hblm_elapsed #(
    parameter int TIME_WIDTH = 32
) (
    input  logic [TIME_WIDTH-1:0]    i_now,
    input  logic [TIME_WIDTH-1:0]    i_ref,
    input  logic [hblm_pkg::CFG_W-1:0] i_limit,
    input  logic                     i_incl,   // 1: elapsed >= limit, 0: elapsed > limit
    output logic                     o_pass
);

    localparam int CW = (TIME_WIDTH > hblm_pkg::CFG_W) ? TIME_WIDTH : hblm_pkg::CFG_W;

    logic [TIME_WIDTH-1:0] diff;
    logic [CW-1:0]         diff_ext;
    logic [CW-1:0]         limit_ext;

    // Wrapping difference, then compare at the wider of the two widths
    assign diff      = i_now - i_ref;
    assign diff_ext  = CW'(diff);
    assign limit_ext = CW'(i_limit);
    assign o_pass    = i_incl ? (diff_ext >= limit_ext) : (diff_ext > limit_ext);

endmodule

// ===== src/hblm_out_buf.sv =====
module hblm_out_buf (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hblm_pkg::t_emit_req         i_req,
    output logic                        o_req_ready,
    output logic                        o_tvalid,
    input  logic                        i_tready,
    output logic                        o_kind,
    output logic [hblm_pkg::SLOT_W-1:0] o_slot,
    output logic                        o_last
);

    // One message is held back until the next one (or the end of the poll)
    // shows whether it is the last of the run.
    logic                        r_pend_vld;
    logic                        r_pend_kind;
    logic [hblm_pkg::SLOT_W-1:0] r_pend_slot;
    logic                        r_out_vld;
    logic                        r_out_kind;
    logic [hblm_pkg::SLOT_W-1:0] r_out_slot;
    logic                        r_out_last;

    logic out_free;
    logic act;
    logic move;

    assign out_free    = !r_out_vld || i_tready;
    assign o_req_ready = !r_pend_vld || out_free;
    assign act         = (i_req.push || i_req.flush) && o_req_ready;
    assign move        = act && r_pend_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            if (move) begin
                r_out_vld <= 1'b1;
            end else if (i_tready) begin
                r_out_vld <= 1'b0;
            end
            if (act) begin
                r_pend_vld <= i_req.push;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_kind <= r_pend_kind;
            r_out_slot <= r_pend_slot;
            r_out_last <= !i_req.push;
        end
        if (act && i_req.push) begin
            r_pend_kind <= i_req.kind;
            r_pend_slot <= i_req.slot;
        end
    end

    assign o_tvalid = r_out_vld;
    assign o_kind   = r_out_kind;
    assign o_slot   = r_out_slot;
    assign o_last   = r_out_last;

endmodule

// ===== src/heartbeat_liveness_monitor_core.sv =====
// Heartbeat liveness monitor. Clients live in MAX_CLIENTS slots; hello, goodbye
// and heartbeat transfers update a slot's presence bit and time stamp and are
// absorbed at once, with s_axis_tready staying high. A poll transfer
// (command 3, carrying now_ms) starts the sequencer: it walks the slots one per
// cycle while the result stream keeps up, through a single shared elapsed-time
// comparator fed by the stamp RAM, clears every present slot silent for more
// than timeout_ms and reports it as a goodbye, then checks the send period with
// the same comparator and, if due, walks the slots again to send a heartbeat to
// every remaining client. The walk reads the single-read-port stamp RAM slot by
// slot. s_axis_tready is low during a poll. Results leave through an output
// register, so the next transfer may be taken while the final result still
// waits; the last result of a poll carries tlast. A poll with nothing to
// report gives no result. All elapsed times wrap modulo 2^TIME_WIDTH.
// Registers: index 0 timeout_ms (reset 1000), index 1 send_period_ms (reset
// 100); other indexes are ignored. Write them only while no poll is in
// progress. The configuration channel is always ready.
module heartbeat_liveness_monitor_core #(
    parameter int MAX_CLIENTS = 16,
    parameter int TIME_WIDTH  = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Command stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [hblm_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [3:0] client_slot, [35:4] now_ms
    input  logic [hblm_pkg::CMD_W-1:0]     s_axis_tuser,  // [1:0] command
    // Message stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [hblm_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [3:0] target_slot
    output logic [0:0]                     m_axis_tuser,  // [0] message_kind
    output logic                           m_axis_tlast,  // last_of_run
    // Register writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [hblm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hblm_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_CLIENTS);
    localparam int SW    = (IDX_W > hblm_pkg::SLOT_W) ? IDX_W : hblm_pkg::SLOT_W;
    localparam int CW    = (TIME_WIDTH > hblm_pkg::NOW_W) ? TIME_WIDTH : hblm_pkg::NOW_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_CLIENTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,      // timeout walk
        S_SEND_CHK,  // send period check
        S_BEAT,      // heartbeat walk
        S_FLUSH      // release the final message
    } t_state;

    t_state r_state, n_state;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic                   r_sent, n_sent;
    logic [MAX_CLIENTS-1:0] r_present, n_present;
    logic [TIME_WIDTH-1:0]  r_last_send, n_last_send;
    logic [TIME_WIDTH-1:0]  r_now;
    logic [hblm_pkg::CFG_W-1:0] r_timeout;
    logic [hblm_pkg::CFG_W-1:0] r_period;

    // Input field extraction
    logic [hblm_pkg::CMD_W-1:0]  in_cmd;
    logic [hblm_pkg::SLOT_W-1:0] in_slot;
    logic [CW-1:0]               now_ext;
    logic [TIME_WIDTH-1:0]       in_now;
    logic [SW-1:0]               slot_ext;
    logic [IDX_W-1:0]            in_idx;
    logic                        in_range;
    logic                        in_acc;
    logic [SW-1:0]               cur_ext;

    // Shared comparator and stamp RAM
    logic [TIME_WIDTH-1:0]      cmp_ref;
    logic [hblm_pkg::CFG_W-1:0] cmp_limit;
    logic                       cmp_incl;
    logic                       cmp_pass;
    logic                       ram_we;
    logic [TIME_WIDTH-1:0]      ram_rdata;

    hblm_pkg::t_emit_req req;
    logic                req_ready;
    logic                out_kind;
    logic [hblm_pkg::SLOT_W-1:0] out_slot;

    assign in_cmd   = s_axis_tuser;
    assign in_slot  = s_axis_tdata[hblm_pkg::SLOT_W-1:0];
    assign now_ext  = CW'(s_axis_tdata[hblm_pkg::SLOT_W +: hblm_pkg::NOW_W]);
    assign in_now   = now_ext[TIME_WIDTH-1:0];
    assign slot_ext = SW'(in_slot);
    assign in_idx   = slot_ext[IDX_W-1:0];
    assign in_range = (32'(in_slot) < 32'(MAX_CLIENTS));
    assign cur_ext  = SW'(r_idx);

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Compare the send time during the send period check, the stamp otherwise
    assign cmp_ref   = (r_state == S_SEND_CHK) ? r_last_send : ram_rdata;
    assign cmp_limit = (r_state == S_SEND_CHK) ? r_period : r_timeout;
    assign cmp_incl  = (r_state == S_SEND_CHK);

    hblm_elapsed #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_elapsed (
        .i_now   (r_now),
        .i_ref   (cmp_ref),
        .i_limit (cmp_limit),
        .i_incl  (cmp_incl),
        .o_pass  (cmp_pass)
    );

    // Read address follows the next index so the stamp is ready when the walk
    // reaches the slot; a held index re-reads the same entry.
    hblm_ram #(
        .WIDTH (TIME_WIDTH),
        .DEPTH (MAX_CLIENTS)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (in_idx),
        .i_wdata (in_now),
        .i_raddr (n_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_sent      = r_sent;
        n_present   = r_present;
        n_last_send = r_last_send;
        ram_we      = 1'b0;
        req         = '0;
        req.slot    = cur_ext[hblm_pkg::SLOT_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (in_cmd == hblm_pkg::CMD_POLL) begin
                        n_state = S_SCAN;
                        n_idx   = '0;
                        n_sent  = 1'b0;
                    end else if (in_range) begin
                        unique case (in_cmd)
                            hblm_pkg::CMD_HELLO: begin
                                // a repeat hello keeps the older stamp
                                if (!r_present[in_idx]) begin
                                    n_present[in_idx] = 1'b1;
                                    ram_we            = 1'b1;
                                end
                            end
                            hblm_pkg::CMD_GOODBYE: begin
                                n_present[in_idx] = 1'b0;
                            end
                            hblm_pkg::CMD_HEARTBEAT: begin
                                ram_we = r_present[in_idx];
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            S_SCAN: begin
                if (r_present[r_idx] && cmp_pass) begin
                    req.push = 1'b1;
                    req.kind = hblm_pkg::KIND_GOODBYE;
                end
                if (!req.push || req_ready) begin
                    if (req.push) begin
                        n_present[r_idx] = 1'b0;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_SEND_CHK;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_SEND_CHK: begin
                n_state = cmp_pass ? S_BEAT : S_FLUSH;
            end
            S_BEAT: begin
                if (r_present[r_idx]) begin
                    req.push = 1'b1;
                    req.kind = hblm_pkg::KIND_HEARTBEAT;
                end
                if (!req.push || req_ready) begin
                    if (req.push) begin
                        n_sent = 1'b1;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_FLUSH;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                req.flush = 1'b1;
                if (req_ready) begin
                    n_state = S_IDLE;
                    // advance the send time only if a heartbeat went out
                    if (r_sent) begin
                        n_last_send = r_now;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_sent      <= 1'b0;
            r_present   <= '0;
            r_last_send <= '0;
            r_timeout   <= hblm_pkg::TIMEOUT_RST;
            r_period    <= hblm_pkg::SEND_PERIOD_RST;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_sent      <= n_sent;
            r_present   <= n_present;
            r_last_send <= n_last_send;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    hblm_pkg::CFG_TIMEOUT:     r_timeout <= i_cfg_data;
                    hblm_pkg::CFG_SEND_PERIOD: r_period  <= i_cfg_data;
                    default: begin
                        // drop writes to unknown indexes
                    end
                endcase
            end
        end
    end

    // Hold the poll time for the whole walk
    always_ff @(posedge i_clk) begin
        if (in_acc && (in_cmd == hblm_pkg::CMD_POLL)) begin
            r_now <= in_now;
        end
    end

    hblm_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .o_req_ready (req_ready),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_kind      (out_kind),
        .o_slot      (out_slot),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = hblm_pkg::M_TDATA_W'(out_slot);
    assign m_axis_tuser = out_kind;

endmodule

// ===== src/hblm_checker.sv =====
module hblm_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [hblm_pkg::CMD_W-1:0]     s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [hblm_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]                     m_axis_tuser,
    input logic                           m_axis_tlast
);

    // A stalled message holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("message changed while stalled");

    // A poll occupies the sequencer, so the command side drops ready
    a_poll_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == hblm_pkg::CMD_POLL) |=>
            !s_axis_tready)
        else $error("ready stayed high after a poll transfer");

    // Client messages are absorbed at once
    a_client_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != hblm_pkg::CMD_POLL) |=>
            s_axis_tready)
        else $error("client message stalled the command stream");

    // Reset leaves the block idle with no message pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not idle after reset");

endmodule

bind heartbeat_liveness_monitor_core hblm_checker u_hblm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== sim/tb_heartbeat_liveness_monitor_core.sv =====
`timescale 1ns / 1ps

module tb_heartbeat_liveness_monitor_core;

    localparam int N_SLOTS     = 16;
    // Longest poll: two slot walks plus overhead, with some margin
    localparam int POLL_CYCLES = 2 * N_SLOTS + 3 + 8;
    localparam int CYCLE_LIMIT = 500000;
    // No register lives at this index; writes to it must have no effect
    localparam logic [hblm_pkg::CFG_IDX_W-1:0] CFG_NONE = hblm_pkg::CFG_SEND_PERIOD + 8'd1;

    // One command transfer as the sender sees it
    typedef struct packed {
        logic [hblm_pkg::CMD_W-1:0]  cmd;
        logic [hblm_pkg::SLOT_W-1:0] slot;
        logic [hblm_pkg::NOW_W-1:0]  now;
    } t_cmd;

    // One outgoing message as the receiver sees it
    typedef struct packed {
        logic                        kind;
        logic [hblm_pkg::SLOT_W-1:0] slot;
        logic                        last;
    } t_msg;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [hblm_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [hblm_pkg::CMD_W-1:0]     s_axis_tuser = hblm_pkg::CMD_HELLO;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [hblm_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]                     m_axis_tuser;
    logic                           m_axis_tlast;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [hblm_pkg::CFG_IDX_W-1:0] i_cfg_index = hblm_pkg::CFG_TIMEOUT;
    logic [hblm_pkg::CFG_W-1:0]     i_cfg_data = '0;

    heartbeat_liveness_monitor_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Liveness tracker mirror: presence bits, stamps, last broadcast, registers
    logic [N_SLOTS-1:0]          present     = '0;
    logic [hblm_pkg::NOW_W-1:0]  stamp [N_SLOTS];
    logic [hblm_pkg::NOW_W-1:0]  sent_at     = '0;
    logic [hblm_pkg::CFG_W-1:0]  timeout_cfg = hblm_pkg::TIMEOUT_RST;
    logic [hblm_pkg::CFG_W-1:0]  period_cfg  = hblm_pkg::SEND_PERIOD_RST;

    t_cmd        cmd_queue [$];   // commands waiting for the driver
    t_msg        msg_expect [$];  // messages the block still owes
    int          cmds_total  = 0;
    int          cmds_taken  = 0;
    int          err_count   = 0;
    int          cycle_count = 0;
    logic        cmd_fire    = 1'b0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          hold_len  = 0;
    int          hold_seq  = 0;
    int          hold_ack  = 0;
    int          hold_left = 0;
    logic [hblm_pkg::NOW_W-1:0] wall_ms = '0;   // running wall clock for well-formed traffic

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH cycle %0d: %s", cycle_count, what);
        err_count++;
    endtask

    // Apply one accepted command to the mirror; a poll queues the messages it owes.
    function automatic void track_command(input t_cmd c);
        t_msg run [N_SLOTS];
        int   n;
        int   i;
        n = 0;
        if (c.cmd == hblm_pkg::CMD_HELLO) begin
            // a repeat hello keeps the older stamp
            if (!present[c.slot]) begin
                present[c.slot] = 1'b1;
                stamp[c.slot]   = c.now;
            end
        end else if (c.cmd == hblm_pkg::CMD_GOODBYE) begin
            present[c.slot] = 1'b0;
        end else if (c.cmd == hblm_pkg::CMD_HEARTBEAT) begin
            if (present[c.slot]) stamp[c.slot] = c.now;
        end else begin
            // Expire silent clients first, in ascending slot order
            for (i = 0; i < N_SLOTS; i++) begin
                if (present[i] && ((c.now - stamp[i]) > timeout_cfg)) begin
                    present[i] = 1'b0;
                    run[n] = '{hblm_pkg::KIND_GOODBYE, hblm_pkg::SLOT_W'(i), 1'b0};
                    n++;
                end
            end
            // Broadcast to survivors when due; advance send time only if someone got one
            if (((c.now - sent_at) >= period_cfg) && (present != '0)) begin
                for (i = 0; i < N_SLOTS; i++) begin
                    if (present[i]) begin
                        run[n] = '{hblm_pkg::KIND_HEARTBEAT, hblm_pkg::SLOT_W'(i), 1'b0};
                        n++;
                    end
                end
                sent_at = c.now;
            end
            if (n > 0) run[n-1].last = 1'b1;
            for (i = 0; i < n; i++) msg_expect.push_back(run[i]);
        end
    endfunction

    task automatic push_cmd(input logic [hblm_pkg::CMD_W-1:0] cmd, input int slot,
                            input logic [hblm_pkg::NOW_W-1:0] now);
        t_cmd c;
        c.cmd  = cmd;
        c.slot = hblm_pkg::SLOT_W'(slot);
        c.now  = now;
        cmd_queue.push_back(c);
        cmds_total++;
    endtask

    // Mostly well-formed traffic on an advancing clock, with some fully random noise
    task automatic queue_traffic(input int n_items);
        int                         k;
        int                         pick;
        int                         span;
        logic [hblm_pkg::CMD_W-1:0] cmd;
        span = (timeout_cfg < 32'd3000) ? int'(timeout_cfg) / 3 + 4 : 500;
        for (k = 0; k < n_items; k++) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                push_cmd(hblm_pkg::CMD_W'($urandom_range(3)), $urandom_range(N_SLOTS - 1),
                         $urandom);
            end else begin
                // rare big jumps exercise wrap and long silences
                if ($urandom_range(19) == 0) wall_ms = wall_ms + $urandom;
                else                         wall_ms = wall_ms + $urandom_range(span);
                pick = $urandom_range(99);
                if (pick < 30)      cmd = hblm_pkg::CMD_HELLO;
                else if (pick < 55) cmd = hblm_pkg::CMD_HEARTBEAT;
                else if (pick < 65) cmd = hblm_pkg::CMD_GOODBYE;
                else                cmd = hblm_pkg::CMD_POLL;
                push_cmd(cmd, $urandom_range(N_SLOTS - 1), wall_ms);
            end
        end
    endtask

    // Register write over the config channel; the mirror follows on the transfer
    task automatic write_reg(input logic [hblm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hblm_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == hblm_pkg::CFG_TIMEOUT)          timeout_cfg = val;
        else if (idx == hblm_pkg::CFG_SEND_PERIOD) period_cfg  = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait for every command to be taken and every message to arrive, then let
    // a trailing poll with nothing to report finish its walk.
    task automatic drain();
        @(posedge i_clk);
        while (cmds_taken != cmds_total || msg_expect.size() != 0) @(posedge i_clk);
        repeat (POLL_CYCLES) @(negedge i_clk);
    endtask

    // Command driver: advance on a transfer, or when idle; idle at random per phase
    always @(negedge i_clk) begin : cmd_drv
        t_cmd nxt;
        logic give;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || cmd_fire) begin
            give = (cmd_queue.size() != 0) && ($urandom_range(99) >= send_idle_pct);
            if (give) begin
                nxt = cmd_queue.pop_front();
                s_axis_tdata <= {{(hblm_pkg::S_TDATA_W - hblm_pkg::NOW_W
                                   - hblm_pkg::SLOT_W){1'b0}}, nxt.now, nxt.slot};
                s_axis_tuser <= nxt.cmd;
            end
            s_axis_tvalid <= give;
        end
    end

    // Message receiver: random stalls, plus a forced hold-off while hold_left runs
    always @(negedge i_clk) begin
        m_axis_tready <= i_rst_n && (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end

    // Long hold-off counter; a new request arrives as a bump of hold_seq
    always @(posedge i_clk) begin
        if (hold_seq != hold_ack) begin
            hold_left <= hold_len;
            hold_ack  <= hold_seq;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: check outgoing messages first, then fold in the accepted command
    always @(posedge i_clk) begin : mon
        t_msg got;
        t_msg want;
        t_cmd took;
        cmd_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tuser[0], m_axis_tdata[hblm_pkg::SLOT_W-1:0], m_axis_tlast};
                if (msg_expect.size() == 0) begin
                    report_mismatch($sformatf("unexpected message kind %0d slot %0d",
                                              got.kind, got.slot));
                end else begin
                    want = msg_expect.pop_front();
                    if (got.kind != want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d (slot %0d)",
                                                  got.kind, want.kind, want.slot));
                    if (got.slot != want.slot)
                        report_mismatch($sformatf("slot %0d, want %0d",
                                                  got.slot, want.slot));
                    if (got.last != want.last)
                        report_mismatch($sformatf("tlast %0d, want %0d (slot %0d)",
                                                  got.last, want.last, want.slot));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                took = '{s_axis_tuser, s_axis_tdata[hblm_pkg::SLOT_W-1:0],
                         s_axis_tdata[hblm_pkg::SLOT_W+hblm_pkg::NOW_W-1:hblm_pkg::SLOT_W]};
                track_command(took);
                cmds_taken++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stim
        int k;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pass at reset settings (timeout 1000, period 100)
        push_cmd(hblm_pkg::CMD_POLL, 0, 32'd0);            // empty poll: nothing to report
        push_cmd(hblm_pkg::CMD_HELLO, 0, 32'hFFFF_FFF0);   // stamp just below wrap
        push_cmd(hblm_pkg::CMD_HELLO, 15, 32'd5);
        push_cmd(hblm_pkg::CMD_HELLO, 0, 32'd10);          // repeat hello keeps old stamp
        push_cmd(hblm_pkg::CMD_GOODBYE, 7, 32'd11);        // absent slot: ignored
        push_cmd(hblm_pkg::CMD_HEARTBEAT, 9, 32'd12);      // absent slot: ignored
        push_cmd(hblm_pkg::CMD_HEARTBEAT, 15, 32'd20);
        push_cmd(hblm_pkg::CMD_HELLO, 5, 32'hFFFF_FFFF);
        push_cmd(hblm_pkg::CMD_POLL, 3, 32'd50);           // across the wrap, nothing due
        push_cmd(hblm_pkg::CMD_POLL, 0, 32'd200);          // broadcast to 0, 5, 15
        push_cmd(hblm_pkg::CMD_GOODBYE, 5, 32'd210);
        push_cmd(hblm_pkg::CMD_POLL, 0, 32'd1100);         // 0 and 15 expire, no survivors
        push_cmd(hblm_pkg::CMD_HELLO, 10, 32'd1500);
        push_cmd(hblm_pkg::CMD_POLL, 0, 32'd1600);         // broadcast to 10 only
        push_cmd(hblm_pkg::CMD_HELLO, 2, 32'd2000);
        push_cmd(hblm_pkg::CMD_POLL, 0, 32'd3000);         // slot 2 exactly at timeout stays
        push_cmd(hblm_pkg::CMD_POLL, 0, 32'd3099);         // one short of the send period
        push_cmd(hblm_pkg::CMD_POLL, 0, 32'd3100);         // exactly the send period
        push_cmd(hblm_pkg::CMD_HELLO, 12, 32'hAAAA_5555);
        push_cmd(hblm_pkg::CMD_POLL, 6, 32'h5555_AAAA);    // huge elapsed: expire all
        drain();

        // Moderate settings, no idling
        write_reg(hblm_pkg::CFG_TIMEOUT, 32'd300);
        write_reg(hblm_pkg::CFG_SEND_PERIOD, 32'd50);
        write_reg(CFG_NONE, 32'd7);                        // no register here: dropped
        wall_ms = $urandom;
        queue_traffic(90);
        drain();

        // Zero timeout and period; sender idles half the time
        write_reg(hblm_pkg::CFG_TIMEOUT, 32'd0);
        write_reg(hblm_pkg::CFG_SEND_PERIOD, 32'd0);
        send_idle_pct = 49;
        stall_pct     = 0;
        queue_traffic(70);
        drain();

        // All-ones timeout and period; receiver stalls half the time
        write_reg(hblm_pkg::CFG_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(hblm_pkg::CFG_SEND_PERIOD, 32'hFFFF_FFFF);
        send_idle_pct = 0;
        stall_pct     = 49;
        queue_traffic(70);
        drain();

        // Random mid-range settings; both sides idle a third of the time
        write_reg(hblm_pkg::CFG_TIMEOUT, $urandom_range(2000, 20));
        write_reg(hblm_pkg::CFG_SEND_PERIOD, $urandom_range(200, 1));
        send_idle_pct = 34;
        stall_pct     = 34;
        queue_traffic(90);
        drain();

        // Back-pressure: fill every slot, broadcast on each poll, and hold the
        // receiver off long enough that the block stalls its command input
        write_reg(hblm_pkg::CFG_TIMEOUT, 32'hFFFF_FFFF);
        write_reg(hblm_pkg::CFG_SEND_PERIOD, 32'd0);
        send_idle_pct = 0;
        stall_pct     = 0;
        for (k = 0; k < N_SLOTS; k++) push_cmd(hblm_pkg::CMD_HELLO, k, wall_ms);
        @(negedge i_clk);
        hold_len = 400;
        hold_seq = hold_seq + 1;
        for (k = 0; k < 12; k++) push_cmd(hblm_pkg::CMD_POLL, k, wall_ms + k);
        drain();

        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/hblm_pkg.sv
src/hblm_ram.sv
src/hblm_elapsed.sv
src/hblm_out_buf.sv
src/heartbeat_liveness_monitor_core.sv
src/hblm_checker.sv
sim/tb_heartbeat_liveness_monitor_core.sv
